FILE: sv/dlbb_pkg.sv
// ============================================================================
// dlbb_pkg
// Shared types, widths and helpers for the distributed-lag basis bank.
// ============================================================================
`default_nettype none

package dlbb_pkg;

    localparam int MAX_TAPS     = 16;
    localparam int MAX_BASIS    = 8;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 16;

    localparam int VALUE_W   = 36;
    localparam int PROD_W    = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int ROW_F_W   = 3;
    localparam int TAP_F_W   = 4;
    localparam int TAP_W     = $clog2(MAX_TAPS);
    localparam int LEN_W     = TAP_W + 1;
    localparam int FILL_W    = $clog2(MAX_TAPS + 1);
    localparam int ROW_W     = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
    localparam int ADDR_W    = $clog2(MAX_BASIS * MAX_TAPS);
    localparam int DEPTH     = MAX_BASIS * MAX_TAPS;

    localparam logic [CFG_IDX_W-1:0] REG_TAPS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BASIS = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] TAPS_RESET  = CFG_W'(15);
    localparam logic [CFG_W-1:0] BASIS_RESET = CFG_W'(8);

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } mac_ctl_t;

    function automatic logic [TAP_W-1:0] eff_taps(input logic [CFG_W-1:0] taps);
        logic [TAP_W-1:0] res;
        if (int'(taps) > MAX_TAPS - 1)
            res = TAP_W'(MAX_TAPS - 1);
        else
            res = TAP_W'(taps);
        return res;
    endfunction

    function automatic logic [CFG_W:0] eff_basis(input logic [CFG_W-1:0] basis);
        logic [CFG_W:0] res;
        if (basis == '0)
            res = (CFG_W + 1)'(1);
        else if (int'(basis) > MAX_BASIS)
            res = (CFG_W + 1)'(MAX_BASIS);
        else
            res = {1'b0, basis};
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: sv/dlbb_coef_mem.sv
// ============================================================================
// dlbb_coef_mem
// Coefficient store: synchronous RAM with per-entry valid bits; unwritten
// entries read as zero.
// ============================================================================
`default_nettype none

module dlbb_coef_mem (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  we,
    input  wire logic [dlbb_pkg::ADDR_W-1:0]           waddr,
    input  wire logic signed [dlbb_pkg::COEF_WIDTH-1:0] wdata,
    input  wire logic [dlbb_pkg::ADDR_W-1:0]           raddr,
    output logic signed [dlbb_pkg::COEF_WIDTH-1:0]     rdata
);

    logic signed [dlbb_pkg::COEF_WIDTH-1:0] mem [dlbb_pkg::DEPTH];
    logic signed [dlbb_pkg::COEF_WIDTH-1:0] rd_reg;
    logic [dlbb_pkg::DEPTH-1:0]             valid_reg;
    logic                                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rd_valid_reg ? rd_reg : '0;

endmodule

`default_nettype wire

FILE: sv/dlbb_mac.sv
// ============================================================================
// dlbb_mac
// Multiply-accumulate pipeline: align sample with RAM data, multiply,
// accumulate one basis row.
// ============================================================================
`default_nettype none

module dlbb_mac (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire dlbb_pkg::mac_ctl_t                      ctl,
    input  wire logic signed [dlbb_pkg::SAMPLE_WIDTH-1:0] smp,
    input  wire logic signed [dlbb_pkg::COEF_WIDTH-1:0]   coef,
    output logic signed [dlbb_pkg::VALUE_W-1:0]          acc,
    output logic                                         done
);

    dlbb_pkg::mac_ctl_t                      ctl1_reg;
    dlbb_pkg::mac_ctl_t                      ctl2_reg;
    logic signed [dlbb_pkg::SAMPLE_WIDTH-1:0] smp1_reg;
    logic signed [dlbb_pkg::PROD_W-1:0]       prod_reg;
    logic signed [dlbb_pkg::VALUE_W-1:0]      acc_reg;
    logic signed [dlbb_pkg::VALUE_W-1:0]      acc_next;
    logic signed [dlbb_pkg::VALUE_W-1:0]      prod_ext;
    logic                                     done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg <= ctl;
            ctl2_reg <= ctl1_reg;
            done_reg <= ctl2_reg.vld && ctl2_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        smp1_reg <= smp;
        prod_reg <= dlbb_pkg::PROD_W'(coef) * dlbb_pkg::PROD_W'(smp1_reg);
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        prod_ext = {{(dlbb_pkg::VALUE_W - dlbb_pkg::PROD_W){prod_reg[dlbb_pkg::PROD_W-1]}},
                    prod_reg};
        acc_next = acc_reg;
        if (ctl2_reg.vld)
        begin
            acc_next = (ctl2_reg.first ? '0 : acc_reg) + prod_ext;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

    a_done_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl2_reg.vld && ctl2_reg.last) |=> done_reg)
        else $error("row completion lost");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(ctl1_reg.vld || ctl2_reg.vld))
        else $error("row completion with taps still in flight");

    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl2_reg.vld && ctl2_reg.first) |=> (acc_reg == $past(prod_ext)))
        else $error("accumulator not restarted on first tap");

endmodule

`default_nettype wire

FILE: sv/distributed_lag_basis_bank_core.sv
// ============================================================================
// distributed_lag_basis_bank_core
// Bank of FIR filters over a sliding sample window; one MAC per cycle while issuing.
// ============================================================================
// One multiply per cycle from the coefficient RAM read port while a row's taps
//   issue; samples go one at a time, the next refused until all rows are out.
// Samples below a full window and coefficient writes leave the block idle.
// Reset: registers back to taps 15 and 8 rows, window fill zero, all
//   coefficients read as zero through per-entry valid bits; no clearing pass.
`default_nettype none

module distributed_lag_basis_bank_core (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    req_valid,
    output logic                                         req_ready,
    input  wire logic                                    req_type,
    input  wire logic signed [dlbb_pkg::SAMPLE_WIDTH-1:0] sample,
    input  wire logic [dlbb_pkg::ROW_F_W-1:0]            coef_row,
    input  wire logic [dlbb_pkg::TAP_F_W-1:0]            coef_tap,
    input  wire logic signed [dlbb_pkg::COEF_WIDTH-1:0]   coef_value,
    output logic                                         res_valid,
    input  wire logic                                    res_ready,
    output logic [dlbb_pkg::ROW_F_W-1:0]                 basis_index,
    output logic signed [dlbb_pkg::VALUE_W-1:0]          basis_value,
    output logic                                         last,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [dlbb_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [dlbb_pkg::CFG_W-1:0]              cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                                   state_reg, state_next;
    logic [dlbb_pkg::CFG_W-1:0]               taps_reg;
    logic [dlbb_pkg::CFG_W-1:0]               basis_reg;
    logic [dlbb_pkg::FILL_W-1:0]              fill_reg, fill_next;
    logic [dlbb_pkg::ROW_W-1:0]               row_reg, row_next;
    logic [dlbb_pkg::TAP_W-1:0]               tap_reg, tap_next;
    logic signed [dlbb_pkg::SAMPLE_WIDTH-1:0] window_reg [dlbb_pkg::MAX_TAPS];

    logic                                     res_valid_reg;
    logic [dlbb_pkg::ROW_F_W-1:0]             res_index_reg;
    logic signed [dlbb_pkg::VALUE_W-1:0]      res_value_reg;
    logic                                     res_last_reg;

    logic [dlbb_pkg::TAP_W-1:0]               eff_t;
    logic [dlbb_pkg::LEN_W-1:0]               len;
    logic [dlbb_pkg::CFG_W:0]                 nb;
    logic                                     row_is_last;
    logic                                     tap_is_last;
    logic                                     req_acc;
    logic                                     smp_acc;
    logic                                     coef_we;
    logic                                     cfg_hit;
    logic                                     out_load;
    logic [dlbb_pkg::TAP_W-1:0]               win_idx;
    logic [dlbb_pkg::ADDR_W-1:0]              waddr;
    logic [dlbb_pkg::ADDR_W-1:0]              raddr;
    logic signed [dlbb_pkg::COEF_WIDTH-1:0]   coef_rd;
    logic signed [dlbb_pkg::VALUE_W-1:0]      mac_acc;
    logic                                     mac_done;
    dlbb_pkg::mac_ctl_t                       mac_ctl;

    assign eff_t       = dlbb_pkg::eff_taps(taps_reg);
    assign len         = {1'b0, eff_t} + dlbb_pkg::LEN_W'(1);
    assign nb          = dlbb_pkg::eff_basis(basis_reg);
    assign row_is_last = ({1'b0, (dlbb_pkg::CFG_W)'(row_reg)} + (dlbb_pkg::CFG_W + 1)'(1)) == nb;
    assign tap_is_last = tap_reg == eff_t;

    assign req_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign req_acc   = req_valid && req_ready;
    assign smp_acc   = req_acc && (req_type == dlbb_pkg::REQ_SAMPLE);
    assign coef_we   = req_acc && (req_type == dlbb_pkg::REQ_COEF)
                       && (int'(coef_row) < dlbb_pkg::MAX_BASIS)
                       && (int'(coef_tap) < dlbb_pkg::MAX_TAPS);
    assign cfg_hit   = cfg_valid && cfg_ready
                       && ((cfg_index == dlbb_pkg::REG_TAPS) || (cfg_index == dlbb_pkg::REG_BASIS));
    assign out_load  = (state_reg == ST_EMIT) && (!res_valid_reg || res_ready);

    assign waddr   = dlbb_pkg::ADDR_W'(coef_row) * dlbb_pkg::ADDR_W'(dlbb_pkg::MAX_TAPS)
                     + dlbb_pkg::ADDR_W'(coef_tap);
    assign raddr   = dlbb_pkg::ADDR_W'(row_reg) * dlbb_pkg::ADDR_W'(dlbb_pkg::MAX_TAPS)
                     + dlbb_pkg::ADDR_W'(tap_reg);
    assign win_idx = dlbb_pkg::TAP_W'(dlbb_pkg::MAX_TAPS - 1) - eff_t + tap_reg;

    always_comb
    begin
        mac_ctl.vld   = (state_reg == ST_ISSUE);
        mac_ctl.first = (tap_reg == '0);
        mac_ctl.last  = tap_is_last;
    end

    // fill count after this cycle's sample, cleared by a taps or basis write
    always_comb
    begin
        fill_next = fill_reg;
        if (cfg_hit)
        begin
            fill_next = '0;
        end
        else if (smp_acc && (int'(fill_reg) < dlbb_pkg::MAX_TAPS))
        begin
            fill_next = fill_reg + dlbb_pkg::FILL_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        tap_next   = tap_reg;
        case (state_reg)
            ST_IDLE:
            begin
                row_next = '0;
                tap_next = '0;
                if (smp_acc && (dlbb_pkg::LEN_W'(fill_next) >= len))
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (tap_is_last)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    tap_next = tap_reg + dlbb_pkg::TAP_W'(1);
                end
            end
            ST_WAIT:
            begin
                if (mac_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    tap_next = '0;
                    if (row_is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + dlbb_pkg::ROW_W'(1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            taps_reg      <= dlbb_pkg::TAPS_RESET;
            basis_reg     <= dlbb_pkg::BASIS_RESET;
            fill_reg      <= '0;
            row_reg       <= '0;
            tap_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            row_reg   <= row_next;
            tap_reg   <= tap_next;
            if (cfg_valid && cfg_ready && (cfg_index == dlbb_pkg::REG_TAPS))
            begin
                taps_reg <= cfg_data;
            end
            if (cfg_valid && cfg_ready && (cfg_index == dlbb_pkg::REG_BASIS))
            begin
                basis_reg <= cfg_data;
            end
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (smp_acc)
        begin
            for (int i = 0; i < dlbb_pkg::MAX_TAPS - 1; i++)
            begin
                window_reg[i] <= window_reg[i + 1];
            end
            window_reg[dlbb_pkg::MAX_TAPS - 1] <= sample;
        end
        if (out_load)
        begin
            res_index_reg <= dlbb_pkg::ROW_F_W'(row_reg);
            res_value_reg <= mac_acc;
            res_last_reg  <= row_is_last;
        end
    end

    dlbb_coef_mem u_coef_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (coef_we),
        .waddr (waddr),
        .wdata (coef_value),
        .raddr (raddr),
        .rdata (coef_rd)
    );

    dlbb_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .smp   (window_reg[win_idx]),
        .coef  (coef_rd),
        .acc   (mac_acc),
        .done  (mac_done)
    );

    assign res_valid   = res_valid_reg;
    assign basis_index = res_index_reg;
    assign basis_value = res_value_reg;
    assign last        = res_last_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == ST_WAIT))
        else $error("row completion outside wait state");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |-> ({1'b0, (dlbb_pkg::CFG_W)'(row_reg)} < nb))
        else $error("row beyond basis count");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= dlbb_pkg::MAX_TAPS)
        else $error("fill count overflow");

    a_emit_full_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |-> (dlbb_pkg::LEN_W'(fill_reg) >= len))
        else $error("sequencing on incomplete window");

endmodule

`default_nettype wire

FILE: verif/basis_result_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// basis_result_checker
// Watches the request, register and result channels of the basis bank, keeps
// its own window, coefficient table and register copies, works out the dot
// products each accepted sample should produce and compares every accepted
// result against the oldest one still due.
// ============================================================================

module basis_result_checker (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     req_valid,
    input  wire logic                                     req_ready,
    input  wire logic                                     req_type,
    input  wire logic signed [dlbb_pkg::SAMPLE_WIDTH-1:0] sample,
    input  wire logic [dlbb_pkg::ROW_F_W-1:0]             coef_row,
    input  wire logic [dlbb_pkg::TAP_F_W-1:0]             coef_tap,
    input  wire logic signed [dlbb_pkg::COEF_WIDTH-1:0]   coef_value,
    input  wire logic                                     res_valid,
    input  wire logic                                     res_ready,
    input  wire logic [dlbb_pkg::ROW_F_W-1:0]             basis_index,
    input  wire logic signed [dlbb_pkg::VALUE_W-1:0]      basis_value,
    input  wire logic                                     last,
    input  wire logic                                     cfg_valid,
    input  wire logic                                     cfg_ready,
    input  wire logic [dlbb_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [dlbb_pkg::CFG_W-1:0]               cfg_data,
    output int                                            errors,
    output int                                            pending,
    output int                                            results_seen
);

    typedef struct packed {
        logic [dlbb_pkg::ROW_F_W-1:0] row;
        logic [dlbb_pkg::VALUE_W-1:0] value;
        logic                         last;
    } basis_result_t;

    logic [dlbb_pkg::CFG_W-1:0]             taps_reg;
    logic [dlbb_pkg::CFG_W-1:0]             basis_reg;
    logic signed [dlbb_pkg::SAMPLE_WIDTH-1:0] window [dlbb_pkg::MAX_TAPS];
    logic signed [dlbb_pkg::COEF_WIDTH-1:0]   coefs [dlbb_pkg::MAX_BASIS][dlbb_pkg::MAX_TAPS];
    int                                     fill;
    basis_result_t                          basis_due [$];
    int                                     mismatch_count;
    int                                     checked_count;

    function automatic int active_lag();
        int lag;
        lag = int'(taps_reg);
        if (lag > dlbb_pkg::MAX_TAPS - 1)
            lag = dlbb_pkg::MAX_TAPS - 1;
        return lag;
    endfunction

    function automatic int active_rows();
        int rows;
        rows = int'(basis_reg);
        if (rows < 1)
            rows = 1;
        if (rows > dlbb_pkg::MAX_BASIS)
            rows = dlbb_pkg::MAX_BASIS;
        return rows;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] basis check: %s", $time, msg);
    endtask

    task automatic apply_register(input logic [dlbb_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [dlbb_pkg::CFG_W-1:0] data);
        case (idx)
            dlbb_pkg::REG_TAPS:
            begin
                taps_reg = data;
                fill = 0;
            end
            dlbb_pkg::REG_BASIS:
            begin
                basis_reg = data;
                fill = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic shift_in_sample(input logic signed [dlbb_pkg::SAMPLE_WIDTH-1:0] s);
        int                                   len;
        int                                   rows;
        int                                   base;
        logic signed [dlbb_pkg::VALUE_W-1:0]  acc;
        logic signed [dlbb_pkg::PROD_W-1:0]   prod;
        basis_result_t                        item;
        for (int i = 0; i < dlbb_pkg::MAX_TAPS - 1; i++)
            window[i] = window[i + 1];
        window[dlbb_pkg::MAX_TAPS - 1] = s;
        if (fill < dlbb_pkg::MAX_TAPS)
            fill++;
        len = active_lag() + 1;
        if (fill >= len)
        begin
            rows = active_rows();
            base = dlbb_pkg::MAX_TAPS - len;
            for (int r = 0; r < rows; r++)
            begin
                acc = '0;
                for (int t = 0; t < len; t++)
                begin
                    prod = dlbb_pkg::PROD_W'(coefs[r][t])
                           * dlbb_pkg::PROD_W'(window[base + t]);
                    acc = acc + dlbb_pkg::VALUE_W'(prod);
                end
                item.row   = dlbb_pkg::ROW_F_W'(r);
                item.value = acc;
                item.last  = (r == rows - 1);
                basis_due.push_back(item);
            end
        end
    endtask

    task automatic check_result();
        basis_result_t want;
        checked_count++;
        if (basis_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result row %0d value %0d last %0b",
                                      basis_index, basis_value, last));
        end
        else
        begin
            want = basis_due.pop_front();
            if (basis_index !== want.row)
                report_mismatch($sformatf("basis_index %0d, want %0d", basis_index, want.row));
            if (basis_value !== want.value)
                report_mismatch($sformatf("row %0d basis_value %0d, want %0d", want.row,
                                          basis_value, $signed(want.value)));
            if (last !== want.last)
                report_mismatch($sformatf("row %0d last %0b, want %0b", want.row,
                                          last, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg  = dlbb_pkg::TAPS_RESET;
            basis_reg = dlbb_pkg::BASIS_RESET;
            fill      = 0;
            for (int i = 0; i < dlbb_pkg::MAX_TAPS; i++)
                window[i] = '0;
            for (int r = 0; r < dlbb_pkg::MAX_BASIS; r++)
                for (int t = 0; t < dlbb_pkg::MAX_TAPS; t++)
                    coefs[r][t] = '0;
            basis_due.delete();
            mismatch_count = 0;
            checked_count  = 0;
            errors       <= 0;
            pending      <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
                check_result();
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (req_valid && req_ready)
            begin
                if (req_type == dlbb_pkg::REQ_COEF)
                begin
                    if (int'(coef_row) < dlbb_pkg::MAX_BASIS &&
                        int'(coef_tap) < dlbb_pkg::MAX_TAPS)
                        coefs[coef_row][coef_tap] = coef_value;
                end
                else
                begin
                    shift_in_sample(sample);
                end
            end
            errors       <= mismatch_count;
            pending      <= basis_due.size();
            results_seen <= checked_count;
        end
    end

endmodule

FILE: verif/distributed_lag_basis_bank_core_test.sv
`timescale 1ns / 100ps
// ============================================================================
// distributed_lag_basis_bank_core_test
// Drives coefficient writes, samples and register writes into the basis bank
// under shifting idle patterns on both channels, with a long result stall and
// drain pauses; the checker beside the block predicts and compares results.
// ============================================================================

module distributed_lag_basis_bank_core_test;

    localparam int QUIET_CYCLES = 32;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_GAP      = 40;
    localparam int LIMIT_NS     = 20_000_000;

    localparam logic [dlbb_pkg::CFG_IDX_W-1:0] REG_SPARE_A = dlbb_pkg::CFG_IDX_W'(2);
    localparam logic [dlbb_pkg::CFG_IDX_W-1:0] REG_SPARE_B = dlbb_pkg::CFG_IDX_W'(3);

    logic                                     clk;
    logic                                     rst_n;
    logic                                     req_valid;
    logic                                     req_ready;
    logic                                     req_type;
    logic signed [dlbb_pkg::SAMPLE_WIDTH-1:0] sample;
    logic [dlbb_pkg::ROW_F_W-1:0]             coef_row;
    logic [dlbb_pkg::TAP_F_W-1:0]             coef_tap;
    logic signed [dlbb_pkg::COEF_WIDTH-1:0]   coef_value;
    logic                                     res_valid;
    logic                                     res_ready = 1'b0;
    logic [dlbb_pkg::ROW_F_W-1:0]             basis_index;
    logic signed [dlbb_pkg::VALUE_W-1:0]      basis_value;
    logic                                     last;
    logic                                     cfg_valid;
    logic                                     cfg_ready;
    logic [dlbb_pkg::CFG_IDX_W-1:0]           cfg_index;
    logic [dlbb_pkg::CFG_W-1:0]               cfg_data;

    int req_idle_pct = 0;
    int res_idle_pct = 0;
    int hold_request = 0;
    int hold_served  = 0;
    int hold_left    = 0;
    int errors;
    int pending;
    int results_seen;
    int items_sent    = 0;
    int settings_used = 0;

    distributed_lag_basis_bank_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .sample      (sample),
        .coef_row    (coef_row),
        .coef_tap    (coef_tap),
        .coef_value  (coef_value),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .basis_index (basis_index),
        .basis_value (basis_value),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    basis_result_checker basis_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_type     (req_type),
        .sample       (sample),
        .coef_row     (coef_row),
        .coef_tap     (coef_tap),
        .coef_value   (coef_value),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .basis_index  (basis_index),
        .basis_value  (basis_value),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("distributed_lag_basis_bank_core: mismatch");
        $finish;
    end

    // hold off for a long stretch on request, else stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            res_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_request)
        begin
            hold_served <= hold_request;
            hold_left   <= HOLD_CYCLES;
            res_ready   <= 1'b0;
        end
        else
        begin
            res_ready <= ($urandom_range(0, 99) >= res_idle_pct);
        end
    end

    function automatic logic signed [dlbb_pkg::SAMPLE_WIDTH-1:0] pick_word();
        logic signed [dlbb_pkg::SAMPLE_WIDTH-1:0] w;
        case ($urandom_range(0, 7))
            0:       w = {1'b1, {(dlbb_pkg::SAMPLE_WIDTH - 1){1'b0}}};
            1:       w = {1'b0, {(dlbb_pkg::SAMPLE_WIDTH - 1){1'b1}}};
            2:       w = '1;
            default: w = dlbb_pkg::SAMPLE_WIDTH'($urandom);
        endcase
        return w;
    endfunction

    task automatic offer_request(input logic                                     kind,
                                 input logic signed [dlbb_pkg::SAMPLE_WIDTH-1:0] s,
                                 input logic [dlbb_pkg::ROW_F_W-1:0]             row,
                                 input logic [dlbb_pkg::TAP_F_W-1:0]             tap,
                                 input logic signed [dlbb_pkg::COEF_WIDTH-1:0]   c);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < req_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid  <= 1'b1;
        req_type   <= kind;
        sample     <= s;
        coef_row   <= row;
        coef_tap   <= tap;
        coef_value <= c;
        do @(posedge clk); while (!req_ready);
        items_sent++;
    endtask

    task automatic send_sample(input logic signed [dlbb_pkg::SAMPLE_WIDTH-1:0] s);
        offer_request(dlbb_pkg::REQ_SAMPLE, s, dlbb_pkg::ROW_F_W'($urandom),
                      dlbb_pkg::TAP_F_W'($urandom), pick_word());
    endtask

    task automatic send_coef(input logic [dlbb_pkg::ROW_F_W-1:0]           row,
                             input logic [dlbb_pkg::TAP_F_W-1:0]           tap,
                             input logic signed [dlbb_pkg::COEF_WIDTH-1:0] c);
        offer_request(dlbb_pkg::REQ_COEF, pick_word(), row, tap, c);
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic program_bank(input logic [dlbb_pkg::CFG_W-1:0] taps,
                                input logic [dlbb_pkg::CFG_W-1:0] basis);
        cfg_valid <= 1'b1;
        cfg_index <= dlbb_pkg::REG_TAPS;
        cfg_data  <= taps;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= dlbb_pkg::REG_BASIS;
        cfg_data  <= basis;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input logic [dlbb_pkg::CFG_W-1:0] taps,
                             input logic [dlbb_pkg::CFG_W-1:0] basis,
                             input int                         count,
                             input bit                         squeeze);
        settle();
        program_bank(taps, basis);
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
            begin
                // drain, then poke an unmapped index mid-fill
                settle();
                cfg_valid <= 1'b1;
                cfg_index <= ($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B;
                cfg_data  <= dlbb_pkg::CFG_W'($urandom);
                do @(posedge clk); while (!cfg_ready);
                cfg_valid <= 1'b0;
            end
            if (squeeze && n == 4)
                hold_request <= hold_request + 1;
            if ($urandom_range(0, 4) == 0)
                send_coef(dlbb_pkg::ROW_F_W'($urandom), dlbb_pkg::TAP_F_W'($urandom),
                          pick_word());
            else
                send_sample(pick_word());
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_type   = dlbb_pkg::REQ_SAMPLE;
        sample     = '0;
        coef_row   = '0;
        coef_tap   = '0;
        coef_value = '0;
        cfg_valid  = 1'b0;
        cfg_index  = dlbb_pkg::REG_TAPS;
        cfg_data   = '0;
        req_idle_pct = 24;
        res_idle_pct <= 82;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: full 16-sample window, eight rows
        send_coef(0, 0, -16'sd32768);
        send_coef(0, 15, 16'sd32767);
        send_coef(7, 0, 16'sd32767);
        send_coef(7, 15, -16'sd32768);
        send_coef(3, 8, -16'sd1);
        send_coef(5, 4, 16'sd1);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        repeat (11) send_sample(pick_word());
        send_sample(16'sd32767);

        run_phase(0, 1, 40, 1'b0);
        run_phase(3, 0, 40, 1'b0);
        run_phase(1, 9, 40, 1'b0);
        run_phase(15, 8, 30, 1'b0);

        settle();
        req_idle_pct = 82;
        res_idle_pct <= 24;
        run_phase(2, 15, 40, 1'b0);
        run_phase(7, 3, 40, 1'b0);
        run_phase(0, 8, 40, 1'b0);
        run_phase(15, 1, 30, 1'b0);

        settle();
        req_idle_pct = 0;
        res_idle_pct <= 0;
        run_phase(4, 2, 40, 1'b1);
        run_phase(1, 5, 40, 1'b0);
        run_phase(6, 7, 40, 1'b0);
        run_phase(0, 4, 30, 1'b0);

        settle();
        $display("run covered %0d request transactions and %0d results over %0d settings",
                 items_sent, results_seen, settings_used);
        $display("lags 0 to 15, row counts 1 to 8 with clamped 0/9/15, spare-index writes, stalls");
        if (errors == 0)
            $display("distributed_lag_basis_bank_core: match");
        else
            $display("distributed_lag_basis_bank_core: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
sv/dlbb_pkg.sv
sv/dlbb_coef_mem.sv
sv/dlbb_mac.sv
sv/distributed_lag_basis_bank_core.sv
verif/basis_result_checker.sv
verif/distributed_lag_basis_bank_core_test.sv
